/* hw/rtl/tcc_pkg.sv */
package tcc_pkg;

    // Default geometry
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 8;

    // Fixed field widths
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // Character codes with control meaning
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Item opcodes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Controller -> datapath
    typedef struct packed {
        logic accept;    // latch input word
        logic clr_step;  // reset sweep: blank cell at counter
        logic cnt_clear; // zero the sweep counter
        logic scr_step;  // one scroll copy/blank step
        logic put;       // store char at cursor and advance
        logic lf;        // row down (no scroll)
        logic cr;        // column to zero
        logic bs;        // backspace
        logic rd;        // issue cell read
        logic emit;      // load result registers
        logic emit_rd;   // result carries the read cell
    } tcc_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic is_read;
        logic is_tab;
        logic is_cr;
        logic is_lf;
        logic is_bs;
        logic col_last;
        logic row_last;
        logic tab_end;   // next put lands on a tab stop
        logic clr_last;
        logic scr_last;
    } tcc_stat_t;

endpackage

/* hw/rtl/tcc_ctrl.sv */
module tcc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tcc_pkg::tcc_stat_t stat,
    output tcc_pkg::tcc_cmd_t  ctl
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_PUT,
        ST_SCROLL,
        ST_RD_WAIT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                priority if (stat.is_read)
                begin
                    ctl.rd     = 1'b1;
                    state_next = ST_RD_WAIT;
                end
                else if (stat.is_cr)
                begin
                    ctl.cr     = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (stat.is_lf)
                begin
                    ctl.lf = 1'b1;
                    if (stat.row_last)
                    begin
                        ctl.cnt_clear = 1'b1;
                        state_next    = ST_SCROLL;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else if (stat.is_bs)
                begin
                    ctl.bs     = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                ctl.put = 1'b1;
                priority if (stat.col_last && stat.row_last)
                begin
                    ctl.cnt_clear = 1'b1;
                    state_next    = ST_SCROLL;
                end
                else if (stat.is_tab && !stat.tab_end)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCROLL:
            begin
                ctl.scr_step = 1'b1;
                if (stat.scr_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_RD_WAIT:
            begin
                ctl.emit    = 1'b1;
                ctl.emit_rd = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_EMIT:
            begin
                ctl.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/tcc_datapath.sv */
module tcc_datapath
#(
    parameter int COLUMNS  = tcc_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcc_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcc_pkg::TAB_STOP_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcc_pkg::tcc_cmd_t           ctl,
    output tcc_pkg::tcc_stat_t          stat,
    input  logic                        cmd,
    input  logic [tcc_pkg::CHAR_W-1:0]  char_code,
    input  logic [tcc_pkg::ADDR_W-1:0]  cell_address,
    input  logic                        cfg_we,
    input  logic [tcc_pkg::ATTR_W-1:0]  cfg_data,
    output logic                        done,
    output logic [tcc_pkg::CELL_W-1:0]  cell_value,
    output logic [tcc_pkg::ADDR_W-1:0]  cursor_offset
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int CLW   = $clog2(COLUMNS);
    localparam int PW    = $clog2(TAB_STOP);
    localparam int OW    = (AW > tcc_pkg::ADDR_W) ? AW : tcc_pkg::ADDR_W;

    localparam logic [AW-1:0]  LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0]  ROW_STEP      = AW'(COLUMNS);
    localparam logic [AW-1:0]  WRAP_BACK     = AW'(COLUMNS - 1);
    localparam logic [CLW-1:0] COL_LAST      = CLW'(COLUMNS - 1);
    localparam logic [PW-1:0]  PHASE_LAST    = PW'(TAB_STOP - 1);
    localparam logic [CW-1:0]  CNT_CLR_LAST  = CW'(CELLS - 1);
    localparam logic [CW-1:0]  CNT_SCR_LAST  = CW'(CELLS);
    localparam logic [CW-1:0]  CNT_COPY_END  = CW'(CELLS - COLUMNS);
    localparam logic [CW-1:0]  CNT_SHIFT     = CW'(COLUMNS);
    localparam logic [31:0]    CELLS_U       = 32'(CELLS);

    // Latched input word
    logic                       cmd_reg;
    logic [tcc_pkg::CHAR_W-1:0] char_reg;
    logic [tcc_pkg::ADDR_W-1:0] addr_reg;

    logic [tcc_pkg::ATTR_W-1:0] attr_reg;
    logic [AW-1:0]              off_reg;
    logic [AW-1:0]              off_next;
    logic [CLW-1:0]             col_reg;
    logic [CLW-1:0]             col_next;
    logic [PW-1:0]              phase_reg;
    logic [PW-1:0]              phase_next;
    logic [CW-1:0]              cnt_reg;
    logic                       done_reg;
    logic [tcc_pkg::CELL_W-1:0] value_reg;
    logic [tcc_pkg::ADDR_W-1:0] cursor_reg;

    logic [tcc_pkg::CELL_W-1:0] mem [CELLS];
    logic [tcc_pkg::CELL_W-1:0] rd_data_reg;

    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic [tcc_pkg::CELL_W-1:0] mem_wd;
    logic                       mem_re;
    logic [AW-1:0]              mem_ra;

    logic                       col_last;
    logic                       row_last;
    logic                       in_range;
    logic                       is_tab;
    logic [OW-1:0]              addr_ext;
    logic [OW-1:0]              off_ext;
    logic [CW-1:0]              cnt_m1;
    logic [CW-1:0]              cnt_src;
    logic [tcc_pkg::CHAR_W-1:0] put_char;

    assign col_last = (col_reg == COL_LAST);
    assign row_last = (off_reg >= LAST_ROW_BASE);
    assign in_range = (32'(addr_reg) < CELLS_U);
    assign is_tab   = (char_reg == tcc_pkg::CH_TAB);
    assign addr_ext = OW'(addr_reg);
    assign off_ext  = OW'(off_reg);
    assign cnt_m1   = cnt_reg - CW'(1);
    assign cnt_src  = cnt_reg + CNT_SHIFT;
    assign put_char = is_tab ? tcc_pkg::CH_SPACE : char_reg;

    assign stat.is_read  = (cmd_reg == tcc_pkg::CMD_READ);
    assign stat.is_tab   = is_tab;
    assign stat.is_cr    = (char_reg == tcc_pkg::CH_CR);
    assign stat.is_lf    = (char_reg == tcc_pkg::CH_LF);
    assign stat.is_bs    = (char_reg == tcc_pkg::CH_BS);
    assign stat.col_last = col_last;
    assign stat.row_last = row_last;
    assign stat.tab_end  = col_last || (phase_reg == PHASE_LAST);
    assign stat.clr_last = (cnt_reg == CNT_CLR_LAST);
    assign stat.scr_last = (cnt_reg == CNT_SCR_LAST);

    // Memory port steering
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = tcc_pkg::BLANK_CELL;
        mem_re = 1'b0;
        mem_ra = '0;
        priority if (ctl.clr_step)
        begin
            mem_we = 1'b1;
            mem_wa = cnt_reg[AW-1:0];
        end
        else if (ctl.scr_step)
        begin
            // read row below, write previous word one row up
            mem_re = (cnt_reg < CNT_COPY_END);
            mem_ra = cnt_src[AW-1:0];
            mem_we = (cnt_reg != '0);
            mem_wa = cnt_m1[AW-1:0];
            mem_wd = (cnt_m1 < CNT_COPY_END) ? rd_data_reg : tcc_pkg::BLANK_CELL;
        end
        else if (ctl.put)
        begin
            mem_we = 1'b1;
            mem_wa = off_reg;
            mem_wd = {attr_reg, put_char};
        end
        else if (ctl.bs)
        begin
            mem_we = (col_reg != '0);
            mem_wa = off_reg - AW'(1);
            mem_wd = {attr_reg, tcc_pkg::CH_SPACE};
        end
        else if (ctl.rd)
        begin
            mem_re = in_range;
            mem_ra = addr_ext[AW-1:0];
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // Cursor update; offset tracked incrementally
    always_comb
    begin
        off_next   = off_reg;
        col_next   = col_reg;
        phase_next = phase_reg;
        priority if (ctl.put)
        begin
            if (col_last)
            begin
                col_next   = '0;
                phase_next = '0;
                off_next   = row_last ? (off_reg - WRAP_BACK) : (off_reg + AW'(1));
            end
            else
            begin
                col_next   = col_reg + CLW'(1);
                phase_next = (phase_reg == PHASE_LAST) ? '0 : (phase_reg + PW'(1));
                off_next   = off_reg + AW'(1);
            end
        end
        else if (ctl.lf)
        begin
            if (!row_last)
            begin
                off_next = off_reg + ROW_STEP;
            end
        end
        else if (ctl.cr)
        begin
            col_next   = '0;
            phase_next = '0;
            off_next   = off_reg - AW'(col_reg);
        end
        else if (ctl.bs)
        begin
            if (col_reg != '0)
            begin
                col_next   = col_reg - CLW'(1);
                phase_next = (phase_reg == '0) ? PHASE_LAST : (phase_reg - PW'(1));
                off_next   = off_reg - AW'(1);
            end
        end
        else
        begin
            off_next = off_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg  <= tcc_pkg::ATTR_RESET;
            off_reg   <= LAST_ROW_BASE;
            col_reg   <= '0;
            phase_reg <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                attr_reg <= cfg_data;
            end
            off_reg   <= off_next;
            col_reg   <= col_next;
            phase_reg <= phase_next;
            if (ctl.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (ctl.clr_step || ctl.scr_step)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            done_reg <= ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= cmd;
            char_reg <= char_code;
            addr_reg <= cell_address;
        end
        if (ctl.emit)
        begin
            value_reg  <= (ctl.emit_rd && in_range) ? rd_data_reg : '0;
            cursor_reg <= off_ext[tcc_pkg::ADDR_W-1:0];
        end
    end

    assign done          = done_reg;
    assign cell_value    = value_reg;
    assign cursor_offset = cursor_reg;

endmodule

/* hw/rtl/text_console_cursor_scroll.sv */
// Text console: one word per start pulse, result on done for one cycle; receiver cannot stall.
// A printable word passes accept, decode, store and result load; a read, CR, LF or BS
// skips the store step, and done comes up with the loaded result.
// A tab repeats the store step for each extra space; a scroll adds a copy step (one copy per cell).
// Reset: async active low; after release a clearing pass blanks every cell of
// the screen with busy high. cfg writes are always taken.
module text_console_cursor_scroll
#(
    parameter int COLUMNS  = tcc_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcc_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcc_pkg::TAB_STOP_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    // command channel
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic [tcc_pkg::CHAR_W-1:0]  char_code,
    input  logic [tcc_pkg::ADDR_W-1:0]  cell_address,

    // result strobe
    output logic                        done,
    output logic [tcc_pkg::CELL_W-1:0]  cell_value,
    output logic [tcc_pkg::ADDR_W-1:0]  cursor_offset,

    // attribute register write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tcc_pkg::ATTR_W-1:0]  cfg_data
);

    tcc_pkg::tcc_cmd_t  ctl;
    tcc_pkg::tcc_stat_t stat;

    // The attribute register has no side effects; take writes any time.
    assign cfg_ready = 1'b1;

    // Sequencer: reset sweep, decode, put loop (tab), scroll, read wait, result.
    tcc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    // Screen memory, cursor (linear offset, column, tab phase), sweep counter,
    // result registers.
    tcc_datapath
    #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cmd           (cmd),
        .char_code     (char_code),
        .cell_address  (cell_address),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .cell_value    (cell_value),
        .cursor_offset (cursor_offset)
    );

endmodule

/* bench/tcc_screen_checker.sv */
`timescale 1ns / 100ps
module tcc_screen_checker
    import tcc_pkg::*;
#(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int ROWS     = ROWS_DEF,
    parameter int TAB_STOP = TAB_STOP_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              cmd,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [ADDR_W-1:0] cell_address,
    input  logic              done,
    input  logic [CELL_W-1:0] cell_value,
    input  logic [ADDR_W-1:0] cursor_offset,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [ATTR_W-1:0] cfg_data,
    output int                mismatch_count,
    output int                words_pending,
    output int                scroll_count
);

    localparam int CELLS = ROWS * COLUMNS;

    typedef struct {
        logic [CELL_W-1:0] cell_data;
        logic [ADDR_W-1:0] offset;
    } screen_reply_t;

    logic [CELL_W-1:0] screen_image [CELLS];
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [ATTR_W-1:0] attr_reg;
    screen_reply_t     replies_due [$];
    screen_reply_t     reply;
    int                faults;
    int                scrolls;

    task automatic note_fault(input string msg);
        faults++;
        if (faults <= 10)
        begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
    endtask

    task automatic shift_rows_up();
        for (int i = 0; i < CELLS - COLUMNS; i++)
        begin
            screen_image[i] = screen_image[i + COLUMNS];
        end
        // new bottom row always gets the fixed blank, not the attribute register
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
        begin
            screen_image[i] = BLANK_CELL;
        end
        scrolls++;
    endtask

    task automatic row_down();
        cur_row++;
        if (cur_row >= ROWS)
        begin
            shift_rows_up();
            cur_row = ROWS - 1;
        end
    endtask

    task automatic place_char(input logic [CHAR_W-1:0] ch);
        screen_image[cur_row * COLUMNS + cur_col] = {attr_reg, ch};
        cur_col++;
        if (cur_col >= COLUMNS)
        begin
            cur_col = 0;
            row_down();
        end
    endtask

    task automatic console_step(input logic c, input logic [CHAR_W-1:0] ch,
                                input logic [ADDR_W-1:0] a, output screen_reply_t r);
        logic stop;
        stop        = 1'b0;
        r.cell_data = '0;
        if (c == CMD_WRITE)
        begin
            case (ch)
                CH_TAB:
                begin
                    // at least one space; stops on a tab stop or on a wrap to column 0
                    for (int n = 0; n < TAB_STOP && !stop; n++)
                    begin
                        place_char(CH_SPACE);
                        stop = (cur_col % TAB_STOP == 0);
                    end
                end
                CH_CR: cur_col = 0;
                CH_LF: row_down();
                CH_BS:
                begin
                    if (cur_col > 0)
                    begin
                        cur_col--;
                        screen_image[cur_row * COLUMNS + cur_col] = {attr_reg, CH_SPACE};
                    end
                end
                default: place_char(ch);
            endcase
        end
        else if (a < CELLS)
        begin
            r.cell_data = screen_image[a];
        end
        r.offset = ADDR_W'(cur_row * COLUMNS + cur_col);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                screen_image[i] = BLANK_CELL;
            end
            cur_row = ROWS - 1;
            cur_col = 0;
            attr_reg = ATTR_RESET;
            replies_due.delete();
            faults = 0;
            scrolls = 0;
            mismatch_count <= 0;
            words_pending <= 0;
            scroll_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (replies_due.size() == 0)
                begin
                    note_fault($sformatf("unrequested word: cell_value=%h cursor_offset=%0d",
                                         cell_value, cursor_offset));
                end
                else
                begin
                    reply = replies_due.pop_front();
                    if (cell_value !== reply.cell_data)
                    begin
                        note_fault($sformatf("cell_value exp %h got %h",
                                             reply.cell_data, cell_value));
                    end
                    if (cursor_offset !== reply.offset)
                    begin
                        note_fault($sformatf("cursor_offset exp %0d got %0d",
                                             reply.offset, cursor_offset));
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                attr_reg = cfg_data;
            end
            if (start && !busy)
            begin
                console_step(cmd, char_code, cell_address, reply);
                replies_due.push_back(reply);
            end
            mismatch_count <= faults;
            words_pending <= replies_due.size();
            scroll_count <= scrolls;
        end
    end

endmodule

/* bench/text_console_cursor_scroll_tb.sv */
`timescale 1ns / 100ps
module text_console_cursor_scroll_tb;

    import tcc_pkg::*;

    localparam int CELLS = ROWS_DEF * COLUMNS_DEF;

    // Slowest legal run: every word forcing a full-screen scroll plus a full tab and
    // sender gaps, about 880 words, plus the clearing pass; taken three times over.
    localparam int CYCLE_LIMIT = 6_000_000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic              cmd          = CMD_WRITE;
    logic [CHAR_W-1:0] char_code    = '0;
    logic [ADDR_W-1:0] cell_address = '0;
    logic              cfg_valid    = 1'b0;
    logic [ATTR_W-1:0] cfg_data     = '0;

    logic              busy;
    logic              done;
    logic [CELL_W-1:0] cell_value;
    logic [ADDR_W-1:0] cursor_offset;
    logic              cfg_ready;

    int mismatch_count;
    int words_pending;
    int scroll_count;

    // Sender pacing and run statistics
    int unsigned sender_idle_pct = 0;
    int          read_words      = 0;
    int          write_words     = 0;
    int          attr_writes     = 0;
    int          cycles          = 0;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    text_console_cursor_scroll dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .char_code     (char_code),
        .cell_address  (cell_address),
        .done          (done),
        .cell_value    (cell_value),
        .cursor_offset (cursor_offset),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Checker sits beside the block: it models the screen and cursor, and compares
    // every done word against the oldest outstanding prediction.
    tcc_screen_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .char_code      (char_code),
        .cell_address   (cell_address),
        .done           (done),
        .cell_value     (cell_value),
        .cursor_offset  (cursor_offset),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending),
        .scroll_count   (scroll_count)
    );

    // Watchdog: a hung block or a lost handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     words_pending);
            $display("text_console_cursor_scroll_tb NOT OK");
            $finish;
        end
    end

    // Offer one word. Random idle cycles go in front of it (start low); start is left
    // high afterwards so back-to-back words need no lowering in between. The word is
    // taken at the first edge where busy is low, which covers the clearing pass too.
    task automatic send_word(input logic c, input logic [CHAR_W-1:0] ch,
                             input logic [ADDR_W-1:0] a);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        cmd          <= c;
        char_code    <= ch;
        cell_address <= a;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (c == CMD_READ)
            read_words++;
        else
            write_words++;
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_word(CMD_WRITE, ch, ADDR_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input int a);
        send_word(CMD_READ, CHAR_W'($urandom_range(0, 255)), ADDR_W'(a));
    endtask

    // Stop sending and hold off until every predicted word has come back and the
    // block has dropped busy. The first edge lets the last accept reach the count.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (words_pending != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    // Attribute write; only ever called with the block idle.
    task automatic set_attribute(input logic [ATTR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        attr_writes++;
    endtask

    // One random word. Reads lean on the bottom rows where text actually lands,
    // with a share of full 11-bit addresses to hit the out-of-range reads. Line
    // feeds are kept rare: the cursor lives on the bottom row, so each one scrolls.
    task automatic random_word();
        int unsigned       pick;
        int unsigned       zone;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(0, 99);
        zone = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom_range(0, 255));
        a    = ADDR_W'($urandom_range(0, 2047));
        if (pick < 30)
        begin
            if (zone < 50)
                a = ADDR_W'($urandom_range(CELLS - 5 * COLUMNS_DEF, CELLS - 1));
            else if (zone < 85)
                a = ADDR_W'($urandom_range(0, CELLS - 1));
            send_word(CMD_READ, ch, a);
        end
        else
        begin
            if (pick < 34)
                ch = CH_LF;
            else if (pick < 38)
                ch = CH_CR;
            else if (pick < 44)
                ch = CH_BS;
            else if (pick < 52)
                ch = CH_TAB;
            send_word(CMD_WRITE, ch, a);
        end
    endtask

    task automatic random_phase(input int count, input int unsigned idle_pct);
        sender_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
        begin
            random_word();
        end
        drain();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, sender pacing at sender_idle_pct = 23.
        sender_idle_pct = 23;

        // Reads right after the clearing pass: corners and out-of-range addresses.
        read_cell(0);
        read_cell(CELLS - 1);
        read_cell(CELLS);
        read_cell(2047);

        // Backspace at column zero does nothing.
        put_char(CH_BS);

        // Character extremes with the reset attribute, then blank one by backspace.
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h80);
        put_char(CH_BS);
        read_cell(CELLS - COLUMNS_DEF + 3);
        drain();

        // Full attribute; tabs from an odd column and from a tab stop, CR, then
        // a line feed that scrolls the whole screen.
        set_attribute(8'hFF);
        put_char(CH_TAB);
        put_char(CH_TAB);
        put_char(CH_CR);
        put_char(CH_LF);
        read_cell(CELLS - 2 * COLUMNS_DEF + 1);

        // Ten tabs from column 0: the last one hits the right edge, wraps and scrolls.
        for (int i = 0; i < 10; i++)
        begin
            put_char(CH_TAB);
        end
        read_cell(CELLS - 2 * COLUMNS_DEF + 72);
        drain();

        // Random part in three pacing phases, each after an attribute change made
        // with the block fully drained.
        set_attribute(8'h00);
        random_phase(280, 23);
        set_attribute(ATTR_W'($urandom_range(1, 254)));
        random_phase(280, 70);
        set_attribute(ATTR_W'($urandom_range(0, 255)));
        random_phase(290, 0);

        // Let any stray word show up before the verdict.
        repeat (16) @(posedge clk);

        $display("covered %0d words (%0d reads, %0d writes), %0d scrolls, %0d attribute writes",
                 read_words + write_words, read_words, write_words, scroll_count,
                 attr_writes);
        if (mismatch_count == 0 && words_pending == 0)
        begin
            $display("text_console_cursor_scroll_tb OK");
        end
        else
        begin
            $display("%0d mismatches, %0d words outstanding", mismatch_count, words_pending);
            $display("text_console_cursor_scroll_tb NOT OK");
        end
        $finish;
    end

endmodule

/* text_console_cursor_scroll.f */
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_ctrl.sv
hw/rtl/tcc_datapath.sv
hw/rtl/text_console_cursor_scroll.sv
bench/tcc_screen_checker.sv
bench/text_console_cursor_scroll_tb.sv
